// ===== rtl/ppa_pkg.sv =====
package ppa_pkg;

    // Depth of the interval ring; a power of two.
    localparam int SAMPLES = 4;
    localparam int RING_W  = $clog2(SAMPLES);

    localparam logic [1:0] OP_EDGE         = 2'd0;
    localparam logic [1:0] OP_LOAD_COUNT   = 2'd1;
    localparam logic [1:0] OP_LOAD_AVERAGE = 2'd2;
    localparam logic [1:0] OP_RESERVED     = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] timestamp_ns;
        logic [63:0] load_value;
    } t_item;

    typedef struct packed {
        logic [31:0] pulse_total;
        logic [63:0] interval_average;
        logic        indicator;
    } t_result;

endpackage

// ===== rtl/ppa_core.sv =====
module ppa_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  ppa_pkg::t_item   i_item,
    output ppa_pkg::t_result o_next
);
    import ppa_pkg::*;

    logic [63:0]       r_prev_time;
    logic [63:0]       n_prev_time;
    logic              r_seen_first;
    logic              n_seen_first;
    logic [63:0]       r_ring [SAMPLES];
    logic [63:0]       n_ring [SAMPLES];
    logic [RING_W-1:0] r_pos;
    logic [RING_W-1:0] n_pos;
    logic [63:0]       r_average;
    logic [63:0]       n_average;
    logic [31:0]       r_total;
    logic [31:0]       n_total;
    logic              r_indicator;
    logic              n_indicator;
    logic [63:0]       ring_sum;

    // Next state for the item at the input register. The ring sum is taken over
    // the ring as it stands after this edge's spacing has been written.
    always_comb begin
        n_prev_time  = r_prev_time;
        n_seen_first = r_seen_first;
        n_ring       = r_ring;
        n_pos        = r_pos;
        n_average    = r_average;
        n_total      = r_total;
        n_indicator  = r_indicator;
        ring_sum     = '0;

        case (i_item.opcode)
            OP_EDGE: begin
                n_indicator = ~r_indicator;
                n_total     = r_total + 32'd1;
                n_prev_time = i_item.timestamp_ns;
                if (!r_seen_first) begin
                    n_seen_first = 1'b1;
                end else begin
                    n_ring[r_pos] = i_item.timestamp_ns - r_prev_time;
                    n_pos         = r_pos + RING_W'(1);
                    for (int k = 0; k < SAMPLES; k++) begin
                        ring_sum = ring_sum + n_ring[k];
                    end
                    if (n_pos == '0) begin
                        n_average = ring_sum >> RING_W;
                    end
                end
            end
            OP_LOAD_COUNT: begin
                n_total = i_item.load_value[31:0];
            end
            OP_LOAD_AVERAGE: begin
                n_average = i_item.load_value;
            end
            default: begin
                // The reserved opcode leaves all state alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time  <= '0;
            r_seen_first <= 1'b0;
            r_pos        <= '0;
            r_average    <= '0;
            r_total      <= '0;
            r_indicator  <= 1'b0;
            for (int k = 0; k < SAMPLES; k++) begin
                r_ring[k] <= '0;
            end
        end else if (i_take) begin
            r_prev_time  <= n_prev_time;
            r_seen_first <= n_seen_first;
            r_pos        <= n_pos;
            r_average    <= n_average;
            r_total      <= n_total;
            r_indicator  <= n_indicator;
            r_ring       <= n_ring;
        end
    end

    assign o_next.pulse_total      = n_total;
    assign o_next.interval_average = n_average;
    assign o_next.indicator        = n_indicator;

`ifndef SYNTHESIS
    a_edge_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.opcode == OP_EDGE |=> r_indicator != $past(r_indicator))
        else $error("indicator did not toggle on a pulse edge");

    a_reserved_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.opcode == OP_RESERVED |=>
            $stable(r_total) && $stable(r_average) && $stable(r_pos))
        else $error("reserved opcode changed state");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_total) && $stable(r_average) && $stable(r_indicator))
        else $error("state changed without a transaction");

    a_pos_only_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen_first |-> r_pos == '0)
        else $error("ring position moved before the first edge");
`endif

endmodule

// ===== rtl/pulse_period_averager.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_timestamp_ns, i_load_value
// result    out        o_out_valid / i_out_stall o_pulse_total, o_interval_average,
//                                                o_indicator
//
// Every transaction on the input channel yields exactly one result transaction,
// showing the counter state after that item. An item waits in the input register
// and moves on when the result register takes its result, so the block
// sustains one item per cycle while the result side does not stall.
// The rate is set by the single state update (edge spacing, four-entry ring sum
// and shift) that sits between the input register and the result register.
// Reset is synchronous and active low; it clears the counters, the ring and all
// valid flags. A stall on the result side holds the result register, then the
// input register, and finally raises o_in_stall.
module pulse_period_averager (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_timestamp_ns,
    input  logic [63:0] i_load_value,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pulse_total,
    output logic [63:0] o_interval_average,
    output logic        o_indicator
);
    import ppa_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_next;
    logic    out_load;
    logic    advance;
    logic    in_accept;

    // The result register can take a new value when it is empty or when its
    // current transaction completes in this cycle.
    assign out_load  = !r_out_valid || !i_out_stall;
    // The item in the input register moves on, and commits its state update,
    // exactly when the result register takes its result.
    assign advance   = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    // Payload registers load on acceptance only and need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.opcode       <= i_opcode;
            r_item.timestamp_ns <= i_timestamp_ns;
            r_item.load_value   <= i_load_value;
        end
    end

    ppa_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (advance),
        .i_item  (r_item),
        .o_next  (core_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_next;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_pulse_total      = r_result.pulse_total;
    assign o_interval_average = r_result.interval_average;
    assign o_indicator        = r_result.indicator;

endmodule
